FILE: rtl/pwmdiv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdiv_pkg
// Shared types, constants and codes for the PWM divider, wrap and level
// calculator.
// ----------------------------------------------------------------------------
package pwmdiv_pkg;

    localparam int MAX_DIVIDER = 255;

    localparam int FREQ_W      = 32;
    localparam int DUTY_W      = 7;
    localparam int SLICE_W     = 3;
    localparam int DIVIDER_W   = 8;
    localparam int COUNT_W     = 16;
    localparam int BOUND_W     = 48;
    localparam int PROD_W      = COUNT_W + DUTY_W;
    localparam int RECIP_W     = 24;
    localparam int SCALED_W    = PROD_W + RECIP_W;
    localparam int LEVEL_SHIFT = 30;
    localparam int DIV_STEPS   = 32;
    localparam int STEP_W      = $clog2(DIV_STEPS + 1);

    localparam logic [FREQ_W-1:0]  MIN_FREQ        = 32'd8;
    localparam logic [DUTY_W-1:0]  FULL_DUTY       = 7'd100;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;
    localparam logic [FREQ_W-1:0]  SYS_CLOCK_RESET = 32'd125000000;
    localparam logic [FREQ_W-1:0]  DIV_LIMIT       = 32'(MAX_DIVIDER - 1);

    // 2^30 / 100 rounded up, exact for any duty product below 2^23
    localparam logic [RECIP_W-1:0] LEVEL_RECIP     = 24'd10737419;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_RANGE  = 2'd1;
    localparam logic [1:0] STATUS_NO_DIV = 2'd2;

    typedef struct packed {
        logic [FREQ_W-1:0]  target_freq;
        logic [DUTY_W-1:0]  duty_percent;
        logic [SLICE_W-1:0] pwm_slice;
        logic               pwm_channel;
    } pwmdiv_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [DIVIDER_W-1:0] clock_divider;
        logic [COUNT_W-1:0]   wrap_value;
        logic [COUNT_W-1:0]   compare_level;
        logic [SLICE_W-1:0]   slice_out;
        logic                 channel_out;
    } pwmdiv_result_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } pwmdiv_seq_stat_t;

endpackage : pwmdiv_pkg
`default_nettype wire

FILE: rtl/pwmdiv_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdiv_divider
// Shared restoring divider: 32-bit dividend by 48-bit divisor, one quotient
// bit per cycle, with a one-cycle done pulse when the quotient is ready.
// ----------------------------------------------------------------------------
module pwmdiv_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [pwmdiv_pkg::FREQ_W-1:0]     dividend,
    input  wire logic [pwmdiv_pkg::BOUND_W-1:0]    divisor,
    output logic      [pwmdiv_pkg::FREQ_W-1:0]     quotient,
    output logic                                   done
);
    import pwmdiv_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [STEP_W-1:0]    cnt_reg, cnt_next;
    logic [FREQ_W-1:0]    quo_reg, quo_next;
    logic [BOUND_W-1:0]   rem_reg, rem_next;
    logic [BOUND_W-1:0]   dsr_reg, dsr_next;
    logic [BOUND_W:0]     trial;
    logic [BOUND_W+1:0]   diff;
    logic                 borrow;

    always_comb
    begin
        trial  = {rem_reg, quo_reg[FREQ_W-1]};
        diff   = {1'b0, trial} - {2'b00, dsr_reg};
        borrow = diff[BOUND_W+1];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = STEP_W'(DIV_STEPS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = borrow ? trial[BOUND_W-1:0] : diff[BOUND_W-1:0];
            quo_next = {quo_reg[FREQ_W-2:0], ~borrow};
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule : pwmdiv_divider
`default_nettype wire

FILE: rtl/pwmdiv_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdiv_seq
// Sequencer that runs one transaction through the range check, the divider
// bound, three passes of the shared divider for divider, clock and wrap, and
// a duty multiply followed by a reciprocal multiply for the level.
// ----------------------------------------------------------------------------
module pwmdiv_seq (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire pwmdiv_pkg::pwmdiv_item_t          item,
    input  wire logic [pwmdiv_pkg::FREQ_W-1:0]     sys_clock_hz,
    input  wire logic                              res_ready,
    output pwmdiv_pkg::pwmdiv_result_t             result,
    output pwmdiv_pkg::pwmdiv_seq_stat_t           stat
);
    import pwmdiv_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_CHECK   = 4'd1;
    localparam logic [3:0] ST_BOUND   = 4'd2;
    localparam logic [3:0] ST_QD_GO   = 4'd3;
    localparam logic [3:0] ST_QD_WAIT = 4'd4;
    localparam logic [3:0] ST_QC_GO   = 4'd5;
    localparam logic [3:0] ST_QC_WAIT = 4'd6;
    localparam logic [3:0] ST_QW_GO   = 4'd7;
    localparam logic [3:0] ST_QW_WAIT = 4'd8;
    localparam logic [3:0] ST_MUL     = 4'd9;
    localparam logic [3:0] ST_LEVEL   = 4'd10;
    localparam logic [3:0] ST_FIN     = 4'd11;

    logic [3:0]           state_reg, state_next;
    logic [FREQ_W-1:0]    freq_reg, freq_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;
    logic [SLICE_W-1:0]   slice_reg, slice_next;
    logic                 chan_reg, chan_next;
    logic [1:0]           status_reg, status_next;
    logic [DIVIDER_W-1:0] div_reg, div_next;
    logic [COUNT_W-1:0]   wrap_reg, wrap_next;
    logic [COUNT_W-1:0]   level_reg, level_next;
    logic [BOUND_W-1:0]   bound_reg, bound_next;
    logic [FREQ_W-1:0]    c_reg, c_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;

    logic [BOUND_W-1:0]   bound_hi;
    logic [BOUND_W-1:0]   bound_lo;
    logic [COUNT_W-1:0]   base;
    logic [SCALED_W-1:0]  scaled;
    logic                 div_start;
    logic [FREQ_W-1:0]    div_dividend;
    logic [BOUND_W-1:0]   div_divisor;
    logic [FREQ_W-1:0]    div_quotient;
    logic                 div_done;

    pwmdiv_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quotient),
        .done     (div_done)
    );

    // operand select for the shared divider
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (state_reg)
            ST_QD_GO:
            begin
                div_start    = 1'b1;
                div_dividend = sys_clock_hz;
                div_divisor  = bound_reg;
            end
            ST_QC_GO:
            begin
                div_start    = 1'b1;
                div_dividend = sys_clock_hz;
                div_divisor  = {{(BOUND_W-DIVIDER_W){1'b0}}, div_reg};
            end
            ST_QW_GO:
            begin
                div_start    = 1'b1;
                div_dividend = c_reg;
                div_divisor  = {{(BOUND_W-FREQ_W){1'b0}}, freq_reg};
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        // count limit times (freq + 1), and 65536 times freq
        bound_lo = {freq_reg, {COUNT_W{1'b0}}};
        bound_hi = bound_lo - {{(BOUND_W-FREQ_W){1'b0}}, freq_reg}
                 + {{(BOUND_W-COUNT_W){1'b0}}, COUNT_MAX};
        base     = (duty_reg == FULL_DUTY) ? (wrap_reg + COUNT_W'(1)) : wrap_reg;
        // division of the duty product by 100
        scaled   = SCALED_W'(prod_reg) * SCALED_W'(LEVEL_RECIP);

        state_next  = state_reg;
        freq_next   = freq_reg;
        duty_next   = duty_reg;
        slice_next  = slice_reg;
        chan_next   = chan_reg;
        status_next = status_reg;
        div_next    = div_reg;
        wrap_next   = wrap_reg;
        level_next  = level_reg;
        bound_next  = bound_reg;
        c_next      = c_reg;
        prod_next   = prod_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    freq_next   = item.target_freq;
                    duty_next   = (item.duty_percent > FULL_DUTY) ? FULL_DUTY
                                                                 : item.duty_percent;
                    slice_next  = item.pwm_slice;
                    chan_next   = item.pwm_channel;
                    status_next = STATUS_OK;
                    div_next    = '0;
                    wrap_next   = '0;
                    level_next  = '0;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (freq_reg < MIN_FREQ || freq_reg > sys_clock_hz)
                begin
                    status_next = STATUS_RANGE;
                    state_next  = ST_FIN;
                end
                else
                begin
                    state_next = ST_BOUND;
                end
            end
            ST_BOUND:
            begin
                bound_next = (freq_reg > {{(FREQ_W-COUNT_W){1'b0}}, COUNT_MAX})
                           ? bound_hi : bound_lo;
                state_next = ST_QD_GO;
            end
            ST_QD_GO:
            begin
                state_next = ST_QD_WAIT;
            end
            ST_QD_WAIT:
            begin
                if (div_done)
                begin
                    if (div_quotient >= DIV_LIMIT)
                    begin
                        status_next = STATUS_NO_DIV;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        div_next   = div_quotient[DIVIDER_W-1:0] + DIVIDER_W'(1);
                        state_next = ST_QC_GO;
                    end
                end
            end
            ST_QC_GO:
            begin
                state_next = ST_QC_WAIT;
            end
            ST_QC_WAIT:
            begin
                if (div_done)
                begin
                    c_next     = div_quotient;
                    state_next = ST_QW_GO;
                end
            end
            ST_QW_GO:
            begin
                state_next = ST_QW_WAIT;
            end
            ST_QW_WAIT:
            begin
                if (div_done)
                begin
                    wrap_next  = div_quotient[COUNT_W-1:0];
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                prod_next  = PROD_W'(base) * PROD_W'(duty_reg);
                state_next = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                level_next = scaled[LEVEL_SHIFT +: COUNT_W];
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        freq_reg   <= freq_next;
        duty_reg   <= duty_next;
        slice_reg  <= slice_next;
        chan_reg   <= chan_next;
        status_reg <= status_next;
        div_reg    <= div_next;
        wrap_reg   <= wrap_next;
        level_reg  <= level_next;
        bound_reg  <= bound_next;
        c_reg      <= c_next;
        prod_reg   <= prod_next;
    end

    assign result.status        = status_reg;
    assign result.clock_divider = div_reg;
    assign result.wrap_value    = wrap_reg;
    assign result.compare_level = level_reg;
    assign result.slice_out     = slice_reg;
    assign result.channel_out   = chan_reg;

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_FIN);

endmodule : pwmdiv_seq
`default_nettype wire

FILE: rtl/pwm_divider_wrap_level_calc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_divider_wrap_level_calc_core
// PWM divider, wrap and compare-level calculator with a registered output.
// ----------------------------------------------------------------------------
// One transaction at a time. out_valid rises once the range check rejects a
// target below 8 or above the system clock, once the first divider pass finds
// that no divider fits, or once the level is ready for a normal result. The
// time is set by the shared 32-step restoring divider, used up to three times
// per transaction (divider bound, divided clock and wrap), one quotient bit
// per cycle; the level then takes a duty multiply followed by a reciprocal
// multiply by 1/100. The input is stalled while a transaction is in progress
// and while a finished result waits for the output register; a result in the
// output register lets the next transaction start. The system clock register
// resets to 125 MHz and is to be written only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_divider_wrap_level_calc_core (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [pwmdiv_pkg::FREQ_W-1:0]          cfg_wdata,
    input  wire logic                                   in_valid,
    output logic                                        in_stall,
    input  wire logic [pwmdiv_pkg::FREQ_W-1:0]          target_freq,
    input  wire logic [pwmdiv_pkg::DUTY_W-1:0]          duty_percent,
    input  wire logic [pwmdiv_pkg::SLICE_W-1:0]         pwm_slice,
    input  wire logic                                   pwm_channel,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output logic [1:0]                                  status,
    output logic [pwmdiv_pkg::DIVIDER_W-1:0]            clock_divider,
    output logic [pwmdiv_pkg::COUNT_W-1:0]              wrap_value,
    output logic [pwmdiv_pkg::COUNT_W-1:0]              compare_level,
    output logic [pwmdiv_pkg::SLICE_W-1:0]              slice_out,
    output logic                                        channel_out
);
    import pwmdiv_pkg::*;

    logic [FREQ_W-1:0]  sys_clock_reg, sys_clock_next;
    logic               out_valid_reg, out_valid_next;
    pwmdiv_result_t     res_reg, res_next;

    pwmdiv_item_t       item;
    pwmdiv_result_t     seq_result;
    pwmdiv_seq_stat_t   seq_stat;
    logic               in_accept;
    logic               res_ready;
    logic               res_load;

    assign item.target_freq  = target_freq;
    assign item.duty_percent = duty_percent;
    assign item.pwm_slice    = pwm_slice;
    assign item.pwm_channel  = pwm_channel;

    assign in_stall  = !seq_stat.idle;
    assign in_accept = in_valid && !in_stall;
    assign res_ready = !out_valid_reg || !out_stall;
    assign res_load  = seq_stat.res_valid && res_ready;

    pwmdiv_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (in_accept),
        .item         (item),
        .sys_clock_hz (sys_clock_reg),
        .res_ready    (res_ready),
        .result       (seq_result),
        .stat         (seq_stat)
    );

    always_comb
    begin
        sys_clock_next = cfg_we ? cfg_wdata : sys_clock_reg;
        res_next       = res_load ? seq_result : res_reg;
        priority if (res_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_clock_reg <= SYS_CLOCK_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sys_clock_reg <= sys_clock_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = res_reg.status;
    assign clock_divider = res_reg.clock_divider;
    assign wrap_value    = res_reg.wrap_value;
    assign compare_level = res_reg.compare_level;
    assign slice_out     = res_reg.slice_out;
    assign channel_out   = res_reg.channel_out;

endmodule : pwm_divider_wrap_level_calc_core
`default_nettype wire

FILE: rtl/pwmdiv_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwmdiv_checker
// Port-level checks for the PWM divider calculator, bound to the top level.
// ----------------------------------------------------------------------------
module pwmdiv_checker (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   in_valid,
    input  wire logic                                   in_stall,
    input  wire logic                                   out_valid,
    input  wire logic                                   out_stall,
    input  wire logic [1:0]                             status,
    input  wire logic [pwmdiv_pkg::DIVIDER_W-1:0]       clock_divider,
    input  wire logic [pwmdiv_pkg::COUNT_W-1:0]         wrap_value,
    input  wire logic [pwmdiv_pkg::COUNT_W-1:0]         compare_level
);
    import pwmdiv_pkg::*;

    // one transaction at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a transaction is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(status)
            && $stable(clock_divider) && $stable(wrap_value)
            && $stable(compare_level)))
    else $error("stalled result changed");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != STATUS_OK) |->
            (clock_divider == '0 && wrap_value == '0 && compare_level == '0))
    else $error("failed result carries non-zero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_OK) |->
            (clock_divider != '0 && 32'(clock_divider) < DIV_LIMIT + 32'd1))
    else $error("divider outside the search range");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_RANGE
            || status == STATUS_NO_DIV))
    else $error("unknown status code");

endmodule : pwmdiv_checker

bind pwm_divider_wrap_level_calc_core pwmdiv_checker u_pwmdiv_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .clock_divider (clock_divider),
    .wrap_value    (wrap_value),
    .compare_level (compare_level)
);
`default_nettype wire
